// ===== sv/srti_pkg.sv =====
// Shared types, constants and the arctangent table for the ship rotate and thrust integrator.
package srti_pkg;

	// Register indexes on the configuration port.
	localparam logic REG_TURN_RATE    = 1'b0;
	localparam logic REG_THRUST_ACCEL = 1'b1;

	// Reset values of the configuration registers.
	localparam logic [31:0] TURN_RATE_RST    = 32'd50332;
	localparam logic [31:0] THRUST_ACCEL_RST = 32'd21475;

	// Turn command codes.
	localparam logic [1:0] TURN_NONE  = 2'd0;
	localparam logic [1:0] TURN_LEFT  = 2'd1;
	localparam logic [1:0] TURN_RIGHT = 2'd2;

	// Pi/2 in Q1.36, the limiting inverse CORDIC gain in Q2.30, and one in Q2.30.
	localparam logic [36:0] HALF_PI_Q36  = 37'd107944301636;
	localparam logic [29:0] INV_GAIN_Q30 = 30'd652032874;
	localparam logic [31:0] ONE_Q30      = 32'h4000_0000;

	// The angle is reduced by pi/2 in three steps: a quotient estimate from the top
	// 24 bits of the angle times floor(2^16 / pi/2), a back-multiplication that leaves
	// the remainder, and one compare-and-subtract that fixes an estimate one too low.
	localparam logic [15:0] HALF_PI_RECIP = 16'd41721;
	localparam int DIV_STEPS = 3;
	localparam logic [4:0] DIV_EST  = 5'd2;
	localparam logic [4:0] DIV_BACK = 5'd1;
	localparam logic [4:0] DIV_FIX  = 5'd0;

	// Input transaction payload.
	typedef struct packed {
		logic [15:0] time_step;
		logic [1:0]  turn_dir;
		logic        thrust_on;
	} in_item_t;

	// Output transaction payload.
	typedef struct packed {
		logic signed [31:0] face_x;
		logic signed [31:0] face_y;
		logic signed [47:0] vel_x;
		logic signed [47:0] vel_y;
		logic signed [47:0] pos_x;
		logic signed [47:0] pos_y;
	} out_item_t;

	// Datapath operations issued by the controller, one per cycle.
	typedef enum logic [3:0] {
		OP_NONE,
		OP_LOAD,
		OP_RMUL,
		OP_DIV,
		OP_ROT,
		OP_CORD,
		OP_GMUL,
		OP_GSTO,
		OP_TMUL,
		OP_THI,
		OP_TLO,
		OP_TADD,
		OP_TACC,
		OP_PMUL,
		OP_PACC,
		OP_OUT
	} op_t;

	// Controller states.
	typedef enum logic [3:0] {
		S_IDLE,
		S_RMUL,
		S_CHECK,
		S_DIV,
		S_ROT,
		S_CORD,
		S_GMUL,
		S_GSTO,
		S_TMUL,
		S_THI,
		S_TLO,
		S_TADD,
		S_TACC,
		S_PMUL,
		S_PACC,
		S_DONE
	} state_t;

	// Command from the controller to the datapath.
	typedef struct packed {
		op_t        op;
		logic       axis;
		logic [4:0] idx;
	} dp_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic skip_turn;
		logic thrust;
	} dp_status_t;

	// Arctangent of 2^-i in Q2.30.
	function automatic logic [31:0] atan_q30(input logic [4:0] i);
		logic [31:0] v;
		case (i)
			5'd0:  v = 32'h3243F6A8;
			5'd1:  v = 32'h1DAC6705;
			5'd2:  v = 32'h0FADBAFC;
			5'd3:  v = 32'h07F56EA6;
			5'd4:  v = 32'h03FEAB76;
			5'd5:  v = 32'h01FFD55B;
			5'd6:  v = 32'h00FFFAAA;
			5'd7:  v = 32'h007FFF55;
			5'd8:  v = 32'h003FFFEA;
			5'd9:  v = 32'h001FFFFD;
			5'd10: v = 32'h000FFFFF;
			5'd11: v = 32'h0007FFFF;
			5'd12: v = 32'h0003FFFF;
			5'd13: v = 32'h0001FFFF;
			5'd14: v = 32'h0000FFFF;
			5'd15: v = 32'h00007FFF;
			5'd16: v = 32'h00003FFF;
			5'd17: v = 32'h00001FFF;
			5'd18: v = 32'h00000FFF;
			5'd19: v = 32'h000007FF;
			5'd20: v = 32'h000003FF;
			5'd21: v = 32'h000001FF;
			5'd22: v = 32'h000000FF;
			5'd23: v = 32'h0000007F;
			5'd24: v = 32'h0000003F;
			5'd25: v = 32'h0000001F;
			5'd26: v = 32'h0000000F;
			5'd27: v = 32'h00000008;
			5'd28: v = 32'h00000004;
			5'd29: v = 32'h00000002;
			5'd30: v = 32'h00000001;
			default: v = 32'h00000000;
		endcase
		return v;
	endfunction

endpackage

// ===== sv/srti_datapath.sv =====
// Datapath: physics state, configuration registers, the multipliers and the CORDIC.
module srti_datapath import srti_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_we,
	input  logic       cfg_index,
	input  logic [31:0] cfg_data,
	input  in_item_t   in_data,
	input  dp_cmd_t    cmd,
	output dp_status_t status,
	output out_item_t  out_data
);

	logic [31:0] turn_rate_q, thrust_accel_q;
	logic [15:0] dt_q;
	logic [1:0]  dir_q;
	logic        thr_q;
	logic signed [31:0] fx_q, fy_q;
	logic signed [47:0] vx_q, vy_q, px_q, py_q;
	logic [47:0] r_q;
	logic [1:0]  quo_q;
	logic [11:0] qe_q;
	logic signed [35:0] x_q, y_q;
	logic signed [33:0] z_q;
	logic [66:0] pa_q;
	logic [63:0] pb_q;
	logic [47:0] pc_q;
	logic [47:0] d_q;
	logic        sign_q;
	out_item_t   out_q;

	logic [34:0] a_mag;
	logic [31:0] a_opb;
	logic [66:0] prod_a;
	logic [47:0] b_opa;
	logic [63:0] prod_b;
	logic signed [35:0] xsel;
	logic signed [31:0] fsel;
	logic signed [47:0] vsel;
	logic [35:0] xabs;
	logic [31:0] fabs;
	logic [47:0] vabs;
	logic [39:0] est_prod;
	logic [48:0] back_prod;
	logic        div_ge;
	logic [1:0]  quad;
	logic signed [35:0] xe, ye, xr, yr;
	logic signed [33:0] z0;
	logic signed [35:0] dx, dy;
	logic signed [33:0] at;
	logic [66:0] gsum;
	logic [31:0] gres;
	logic [63:0] tsum;
	logic [63:0] psum;
	logic [47:0] pinc;

	// Operand selection and magnitudes for the current axis.
	always_comb begin
		xsel = cmd.axis ? y_q : x_q;
		fsel = cmd.axis ? fy_q : fx_q;
		vsel = cmd.axis ? vy_q : vx_q;
		xabs = xsel[35] ? 36'(-xsel) : 36'(xsel);
		fabs = fsel[31] ? 32'(-fsel) : 32'(fsel);
		vabs = vsel[47] ? 48'(-vsel) : 48'(vsel);
	end

	// Multiplier A serves the gain correction and the facing times acceleration product.
	always_comb begin
		if (cmd.op == OP_GMUL) begin
			a_mag = xabs[34:0];
			a_opb = {2'b00, INV_GAIN_Q30};
		end else begin
			a_mag = {3'b000, fabs};
			a_opb = thrust_accel_q;
		end
		prod_a = {32'b0, a_mag} * {35'b0, a_opb};
	end

	// Multiplier B multiplies by the time step.
	always_comb begin
		case (cmd.op)
			OP_RMUL: b_opa = {16'b0, turn_rate_q};
			OP_THI:  b_opa = {16'b0, pa_q[63:32]};
			OP_TLO:  b_opa = {16'b0, pa_q[31:0]};
			default: b_opa = vabs;
		endcase
		prod_b = {16'b0, b_opa} * {48'b0, dt_q};
	end

	// Angle reduction by pi/2: quotient estimate, back-multiplication and final compare.
	always_comb begin
		est_prod  = {16'b0, r_q[47:24]} * {24'b0, HALF_PI_RECIP};
		back_prod = {37'b0, qe_q} * {12'b0, HALF_PI_Q36};
		div_ge    = r_q >= {11'b0, HALF_PI_Q36};
	end

	// Quarter-turn pre-rotation and the starting residual angle.
	always_comb begin
		quad = (dir_q == TURN_RIGHT) ? 2'(2'd0 - quo_q) : quo_q;
		xe   = {{4{fx_q[31]}}, fx_q};
		ye   = {{4{fy_q[31]}}, fy_q};
		case (quad)
			2'd1: begin
				xr = -ye;
				yr = xe;
			end
			2'd2: begin
				xr = -xe;
				yr = -ye;
			end
			2'd3: begin
				xr = ye;
				yr = -xe;
			end
			default: begin
				xr = xe;
				yr = ye;
			end
		endcase
		z0 = (dir_q == TURN_RIGHT) ? -$signed({3'b000, r_q[36:6]})
			: $signed({3'b000, r_q[36:6]});
	end

	// CORDIC micro-rotation terms.
	always_comb begin
		dx = y_q >>> cmd.idx;
		dy = x_q >>> cmd.idx;
		at = $signed({2'b00, atan_q30(cmd.idx)});
	end

	// Rounding of the gain, thrust and position products.
	always_comb begin
		gsum = pa_q + 67'h2000_0000;
		gres = sign_q ? 32'(32'd0 - gsum[61:30]) : gsum[61:30];
		tsum = pb_q + {48'b0, pc_q[47:32]} + 64'd512;
		psum = pb_q + 64'h8_0000;
		pinc = {4'b0, psum[63:20]};
	end

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			turn_rate_q    <= TURN_RATE_RST;
			thrust_accel_q <= THRUST_ACCEL_RST;
		end else if (cfg_we) begin
			if (cfg_index == REG_TURN_RATE) begin
				turn_rate_q <= cfg_data;
			end else begin
				thrust_accel_q <= cfg_data;
			end
		end
	end

	// Physics state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fx_q <= '0;
			fy_q <= ONE_Q30;
			vx_q <= '0;
			vy_q <= '0;
			px_q <= '0;
			py_q <= '0;
		end else begin
			case (cmd.op)
				OP_GSTO: begin
					if (cmd.axis) begin
						fy_q <= gres;
					end else begin
						fx_q <= gres;
					end
				end
				OP_TACC: begin
					if (cmd.axis) begin
						vy_q <= vy_q + (sign_q ? -d_q : d_q);
					end else begin
						vx_q <= vx_q + (sign_q ? -d_q : d_q);
					end
				end
				OP_PACC: begin
					if (cmd.axis) begin
						py_q <= py_q + (sign_q ? -pinc : pinc);
					end else begin
						px_q <= px_q + (sign_q ? -pinc : pinc);
					end
				end
				default: begin
				end
			endcase
		end
	end

	// Working registers of the datapath.
	always_ff @(posedge clk) begin
		case (cmd.op)
			OP_LOAD: begin
				dt_q  <= in_data.time_step;
				dir_q <= in_data.turn_dir;
				thr_q <= in_data.thrust_on;
			end
			OP_RMUL: begin
				r_q   <= prod_b[47:0];
				quo_q <= '0;
			end
			OP_DIV: begin
				case (cmd.idx)
					DIV_EST: begin
						qe_q <= est_prod[39:28];
					end
					DIV_BACK: begin
						r_q   <= r_q - back_prod[47:0];
						quo_q <= qe_q[1:0];
					end
					DIV_FIX: begin
						// The estimate is at most one short of the true quotient.
						if (div_ge) begin
							r_q   <= r_q - {11'b0, HALF_PI_Q36};
							quo_q <= quo_q + 2'd1;
						end
					end
					default: begin
					end
				endcase
			end
			OP_ROT: begin
				x_q <= xr;
				y_q <= yr;
				z_q <= z0;
			end
			OP_CORD: begin
				if (!z_q[33]) begin
					x_q <= x_q - dx;
					y_q <= y_q + dy;
					z_q <= z_q - at;
				end else begin
					x_q <= x_q + dx;
					y_q <= y_q - dy;
					z_q <= z_q + at;
				end
			end
			OP_GMUL: begin
				pa_q   <= prod_a;
				sign_q <= xsel[35];
			end
			OP_TMUL: begin
				pa_q   <= prod_a;
				sign_q <= fsel[31];
			end
			OP_THI: begin
				pb_q <= prod_b;
			end
			OP_TLO: begin
				pc_q <= prod_b[47:0];
			end
			OP_TADD: begin
				d_q <= tsum[57:10];
			end
			OP_PMUL: begin
				pb_q   <= prod_b;
				sign_q <= vsel[47];
			end
			OP_OUT: begin
				out_q.face_x <= fx_q;
				out_q.face_y <= fy_q;
				out_q.vel_x  <= vx_q;
				out_q.vel_y  <= vy_q;
				out_q.pos_x  <= px_q;
				out_q.pos_y  <= py_q;
			end
			default: begin
			end
		endcase
	end

	// Status back to the controller.
	always_comb begin
		status.skip_turn = ((dir_q != TURN_LEFT) && (dir_q != TURN_RIGHT)) || (r_q == '0);
		status.thrust    = thr_q;
	end

	assign out_data = out_q;

endmodule

// ===== sv/srti_ctrl.sv =====
// Controller: sequences one tick through division, CORDIC, thrust and position steps.
module srti_ctrl import srti_pkg::*; #(
	parameter int CORDIC_STEPS = 16
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	output logic       out_valid,
	input  logic       out_ready,
	input  dp_status_t status,
	output dp_cmd_t    cmd
);

	localparam int CntW = ($clog2(CORDIC_STEPS) > 4) ? $clog2(CORDIC_STEPS) : 4;
	localparam logic [CntW-1:0] DivLast  = CntW'(DIV_STEPS - 1);
	localparam logic [CntW-1:0] CordLast = CntW'(CORDIC_STEPS - 1);

	state_t state_q, state_d;
	logic [CntW-1:0] cnt_q, cnt_d;
	logic axis_q, axis_d;
	logic out_valid_q, out_valid_d;

	// State, counter, axis and output-valid registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			cnt_q       <= '0;
			axis_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			cnt_q       <= cnt_d;
			axis_q      <= axis_d;
			out_valid_q <= out_valid_d;
		end
	end

	// Next state and datapath commands.
	always_comb begin
		state_d     = state_q;
		cnt_d       = cnt_q;
		axis_d      = axis_q;
		out_valid_d = out_valid_q && !out_ready;
		cmd.op      = OP_NONE;
		cmd.axis    = axis_q;
		cmd.idx     = 5'(cnt_q);
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.op  = OP_LOAD;
					state_d = S_RMUL;
				end
			end
			S_RMUL: begin
				cmd.op  = OP_RMUL;
				state_d = S_CHECK;
			end
			S_CHECK: begin
				axis_d = 1'b0;
				if (status.skip_turn) begin
					state_d = status.thrust ? S_TMUL : S_PMUL;
				end else begin
					cnt_d   = DivLast;
					state_d = S_DIV;
				end
			end
			S_DIV: begin
				cmd.op = OP_DIV;
				cnt_d  = cnt_q - 1'b1;
				if (cnt_q == '0) begin
					state_d = S_ROT;
				end
			end
			S_ROT: begin
				cmd.op  = OP_ROT;
				cnt_d   = '0;
				state_d = S_CORD;
			end
			S_CORD: begin
				cmd.op = OP_CORD;
				cnt_d  = cnt_q + 1'b1;
				if (cnt_q == CordLast) begin
					axis_d  = 1'b0;
					state_d = S_GMUL;
				end
			end
			S_GMUL: begin
				cmd.op  = OP_GMUL;
				state_d = S_GSTO;
			end
			S_GSTO: begin
				cmd.op = OP_GSTO;
				axis_d = !axis_q;
				if (axis_q) begin
					state_d = status.thrust ? S_TMUL : S_PMUL;
				end else begin
					state_d = S_GMUL;
				end
			end
			S_TMUL: begin
				cmd.op  = OP_TMUL;
				state_d = S_THI;
			end
			S_THI: begin
				cmd.op  = OP_THI;
				state_d = S_TLO;
			end
			S_TLO: begin
				cmd.op  = OP_TLO;
				state_d = S_TADD;
			end
			S_TADD: begin
				cmd.op  = OP_TADD;
				state_d = S_TACC;
			end
			S_TACC: begin
				cmd.op  = OP_TACC;
				axis_d  = !axis_q;
				state_d = axis_q ? S_PMUL : S_TMUL;
			end
			S_PMUL: begin
				cmd.op  = OP_PMUL;
				state_d = S_PACC;
			end
			S_PACC: begin
				cmd.op  = OP_PACC;
				axis_d  = !axis_q;
				state_d = axis_q ? S_DONE : S_PMUL;
			end
			S_DONE: begin
				// Load the output register once the previous result has left.
				if (!out_valid_q || out_ready) begin
					cmd.op      = OP_OUT;
					out_valid_d = 1'b1;
					state_d     = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = out_valid_q;

endmodule

// ===== sv/ship_rotate_thrust_integrator.sv =====
// Top level of the ship rotate and thrust integrator.
//
//  Channel | Direction | Handshake            | Payload
//  in      | input     | in_valid / in_ready   | in_data (time_step, turn_dir, thrust_on)
//  out     | output    | out_valid / out_ready | out_data (facing, velocity, position)
//  cfg     | input     | cfg_we                | cfg_index, cfg_data
//
// From one accepted transaction to the next, a tick runs through the angle reduction
// and the CORDIC iterations when it turns, the two-axis thrust steps when thrust is on,
// and the two-axis position steps.
// One tick is in work at a time; the next transaction is taken once the result is in the
// output register, which holds it while out_ready is low.
// Reset restores the unit facing along +y, zero velocity and position, and default gains.
module ship_rotate_thrust_integrator import srti_pkg::*; #(
	parameter int CORDIC_STEPS = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic        cfg_index,
	input  logic [31:0] cfg_data,
	input  logic        in_valid,
	output logic        in_ready,
	input  in_item_t    in_data,
	output logic        out_valid,
	input  logic        out_ready,
	output out_item_t   out_data
);

	dp_cmd_t    cmd;
	dp_status_t status;

	// Sequencer.
	srti_ctrl #(
		.CORDIC_STEPS(CORDIC_STEPS)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.status    (status),
		.cmd       (cmd)
	);

	// Arithmetic and state.
	srti_datapath u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_data   (in_data),
		.cmd       (cmd),
		.status    (status),
		.out_data  (out_data)
	);

endmodule

// ===== tb/sv/ship_rotate_thrust_integrator_tb.sv =====
// Self-checking testbench for the ship rotate and thrust integrator.
module ship_rotate_thrust_integrator_tb;
	import srti_pkg::*;

	localparam int STEPS = 16;
	localparam int TICK_CYCLES = 60;

	// Arctangent of 2^-i in Q2.30, kept locally for the predictor.
	localparam logic [31:0] ARCTAN [0:15] = '{
		32'h3243F6A8, 32'h1DAC6705, 32'h0FADBAFC, 32'h07F56EA6,
		32'h03FEAB76, 32'h01FFD55B, 32'h00FFFAAA, 32'h007FFF55,
		32'h003FFFEA, 32'h001FFFFD, 32'h000FFFFF, 32'h0007FFFF,
		32'h0003FFFF, 32'h0001FFFF, 32'h0000FFFF, 32'h00007FFF
	};

	// Predicts each tick of the ship state and checks the results against it.
	class ship_scoreboard;
		logic [31:0] turn_rate, thrust_accel;
		logic [31:0] face_x, face_y;
		logic [47:0] vel_x, vel_y, pos_x, pos_y;
		out_item_t expected_ticks[$];
		int errors;

		function new();
			turn_rate = TURN_RATE_RST;
			thrust_accel = THRUST_ACCEL_RST;
			face_x = '0;
			face_y = ONE_Q30;
			vel_x = '0;
			vel_y = '0;
			pos_x = '0;
			pos_y = '0;
			errors = 0;
		endfunction

		// Product shifted right with rounding half away from zero.
		function logic [63:0] scale_round(longint a, logic [63:0] b, int s);
			logic [63:0] mag, p;
			mag = (a < 0) ? -a : a;
			p = (mag * b + (64'd1 << (s - 1))) >> s;
			return (a < 0) ? -p : p;
		endfunction

		// Facing times acceleration times time step, rounded to Q16.32.
		function logic [63:0] thrust_step(longint f, logic [63:0] dt);
			logic [63:0] mag, m1, t, d;
			mag = (f < 0) ? -f : f;
			m1 = mag * {32'd0, thrust_accel};
			t = (m1 >> 32) * dt + (((m1 & 64'hFFFF_FFFF) * dt) >> 32);
			d = (t + 64'd512) >> 10;
			return (f < 0) ? -d : d;
		endfunction

		// Turns the facing vector by the commanded angle.
		function void rotate(logic [1:0] dir, logic [63:0] dt);
			logic [63:0] r, q, rem, gx, gy;
			logic [1:0] quad;
			longint x, y, z, t, dx, dy;
			r = {32'd0, turn_rate} * dt;
			if ((dir != TURN_LEFT && dir != TURN_RIGHT) || r == 0)
				return;
			q = r / {27'd0, HALF_PI_Q36};
			rem = r - q * {27'd0, HALF_PI_Q36};
			quad = q[1:0];
			z = longint'(rem >> 6);
			if (dir == TURN_RIGHT) begin
				quad = 2'd0 - quad;
				z = -z;
			end
			x = longint'(signed'(face_x));
			y = longint'(signed'(face_y));
			for (int i = 0; i < quad; i++) begin
				t = x;
				x = -y;
				y = t;
			end
			for (int i = 0; i < STEPS; i++) begin
				dx = y >>> i;
				dy = x >>> i;
				if (z >= 0) begin
					x -= dx;
					y += dy;
					z -= longint'(ARCTAN[i]);
				end else begin
					x += dx;
					y -= dy;
					z += longint'(ARCTAN[i]);
				end
			end
			gx = scale_round(x, {34'd0, INV_GAIN_Q30}, 30);
			gy = scale_round(y, {34'd0, INV_GAIN_Q30}, 30);
			face_x = gx[31:0];
			face_y = gy[31:0];
		endfunction

		// Notes an accepted tick and queues the state it should produce.
		function void note_tick(in_item_t it);
			logic [63:0] dt, inc;
			out_item_t res;
			dt = {48'd0, it.time_step};
			rotate(it.turn_dir, dt);
			if (it.thrust_on) begin
				inc = thrust_step(longint'(signed'(face_x)), dt);
				vel_x = vel_x + inc[47:0];
				inc = thrust_step(longint'(signed'(face_y)), dt);
				vel_y = vel_y + inc[47:0];
			end
			inc = scale_round(longint'(signed'(vel_x)), dt, 20);
			pos_x = pos_x + inc[47:0];
			inc = scale_round(longint'(signed'(vel_y)), dt, 20);
			pos_y = pos_y + inc[47:0];
			res.face_x = face_x;
			res.face_y = face_y;
			res.vel_x = vel_x;
			res.vel_y = vel_y;
			res.pos_x = pos_x;
			res.pos_y = pos_y;
			expected_ticks.push_back(res);
		endfunction

		task report(string what, logic [63:0] got, logic [63:0] want);
			$display("mismatch %s: got %h expected %h", what, got, want);
			errors++;
		endtask

		// Compares one result transaction with the oldest expected tick.
		task check_tick(out_item_t got);
			out_item_t want;
			if (expected_ticks.size() == 0) begin
				report("unexpected result", 64'(got.face_x), 64'd0);
				return;
			end
			want = expected_ticks.pop_front();
			if (got.face_x !== want.face_x) report("face_x", 64'(got.face_x), 64'(want.face_x));
			if (got.face_y !== want.face_y) report("face_y", 64'(got.face_y), 64'(want.face_y));
			if (got.vel_x !== want.vel_x) report("vel_x", 64'(got.vel_x), 64'(want.vel_x));
			if (got.vel_y !== want.vel_y) report("vel_y", 64'(got.vel_y), 64'(want.vel_y));
			if (got.pos_x !== want.pos_x) report("pos_x", 64'(got.pos_x), 64'(want.pos_x));
			if (got.pos_y !== want.pos_y) report("pos_y", 64'(got.pos_y), 64'(want.pos_y));
		endtask
	endclass

	logic clk, arst_n;
	logic cfg_we, cfg_index;
	logic [31:0] cfg_data;
	logic in_valid, in_ready, out_valid, out_ready;
	in_item_t in_data;
	out_item_t out_data;

	ship_scoreboard sb = new();
	bit calm = 0;
	bit long_hold = 0;

	ship_rotate_thrust_integrator #(.CORDIC_STEPS(STEPS)) dut (
		.clk(clk), .arst_n(arst_n),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
		.out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
	);

	initial begin
		clk = 0;
		forever #6 clk = ~clk;
	end

	// Watchdog for a hung block.
	initial begin
		#(12 * 2000000);
		$display("FAIL");
		$finish;
	end

	// Receiver: random stall bursts, one long hold-off when asked.
	initial begin : receiver
		int stall;
		stall = 0;
		out_ready = 0;
		forever begin
			@(negedge clk);
			if (long_hold) begin
				long_hold = 0;
				stall = 400;
			end
			if (stall > 0) begin
				out_ready <= 0;
				stall--;
			end else begin
				out_ready <= 1;
				if (!calm && $urandom_range(0, 5) == 0)
					stall = $urandom_range(1, 12);
			end
		end
	end

	// Result transactions are checked at the rising edge.
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready)
			sb.check_tick(out_data);
	end

	// Offers one tick and waits until it is accepted.
	task send_tick(logic [15:0] dt, logic [1:0] dir, logic thr);
		@(negedge clk);
		if (!calm && $urandom_range(0, 3) == 0) begin
			in_valid <= 0;
			repeat ($urandom_range(1, 12)) @(negedge clk);
		end
		in_valid <= 1;
		in_data <= '{time_step: dt, turn_dir: dir, thrust_on: thr};
		do @(posedge clk); while (!in_ready);
		sb.note_tick(in_data);
	endtask

	// Waits for all results, then writes one register while the block is idle.
	task write_reg(logic idx, logic [31:0] val);
		@(negedge clk);
		in_valid <= 0;
		while (sb.expected_ticks.size() != 0) @(posedge clk);
		repeat (TICK_CYCLES) @(negedge clk);
		cfg_we <= 1;
		cfg_index <= idx;
		cfg_data <= val;
		@(negedge clk);
		cfg_we <= 0;
		if (idx == REG_TURN_RATE)
			sb.turn_rate = val;
		else
			sb.thrust_accel = val;
	endtask

	task random_ticks(int n);
		logic [15:0] dt;
		for (int k = 0; k < n; k++) begin
			dt = ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'($urandom_range(0, 2047));
			send_tick(dt, 2'($urandom_range(0, 3)), 1'($urandom));
		end
	endtask

	initial begin
		arst_n = 0;
		cfg_we = 0;
		cfg_index = REG_TURN_RATE;
		cfg_data = '0;
		in_valid = 0;
		in_data = '0;
		repeat (8) @(negedge clk);
		arst_n = 1;

		// Directed ticks: zero and full time steps, each turn code, thrust.
		send_tick(16'd0, TURN_LEFT, 1'b1);
		send_tick(16'hFFFF, TURN_NONE, 1'b1);
		send_tick(16'hFFFF, TURN_LEFT, 1'b0);
		send_tick(16'hFFFF, TURN_RIGHT, 1'b1);
		send_tick(16'hFFFF, 2'd3, 1'b1);
		send_tick(16'd1, TURN_RIGHT, 1'b0);
		send_tick(16'd4096, TURN_LEFT, 1'b1);

		// Largest gains: many quarter turns and wrapping velocity.
		write_reg(REG_TURN_RATE, 32'hFFFF_FFFF);
		write_reg(REG_THRUST_ACCEL, 32'hFFFF_FFFF);
		send_tick(16'hFFFF, TURN_LEFT, 1'b1);
		send_tick(16'hFFFF, TURN_RIGHT, 1'b1);
		send_tick(16'h8000, TURN_LEFT, 1'b1);
		send_tick(16'h1234, TURN_RIGHT, 1'b1);
		send_tick(16'hFFFF, TURN_NONE, 1'b1);
		send_tick(16'hFFFF, 2'd3, 1'b0);

		// Zero gains: no turn at all and no thrust.
		write_reg(REG_TURN_RATE, 32'd0);
		write_reg(REG_THRUST_ACCEL, 32'd0);
		send_tick(16'hFFFF, TURN_LEFT, 1'b1);
		send_tick(16'hFFFF, TURN_RIGHT, 1'b1);
		random_ticks(60);

		// Random gain settings, with the block held full once.
		for (int ph = 0; ph < 5; ph++) begin
			write_reg(REG_TURN_RATE, $urandom);
			write_reg(REG_THRUST_ACCEL, $urandom);
			if (ph == 1)
				long_hold = 1;
			random_ticks(100);
		end

		// Gentle default-like gains, last part without idling.
		write_reg(REG_TURN_RATE, 32'd50332);
		write_reg(REG_THRUST_ACCEL, 32'd21475);
		random_ticks(40);
		calm = 1;
		random_ticks(80);

		@(negedge clk);
		in_valid <= 0;
		while (sb.expected_ticks.size() != 0) @(posedge clk);
		repeat (TICK_CYCLES) @(posedge clk);
		if (sb.errors == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule
